// File: src/pttt_pkg.sv
`default_nettype none
package pttt_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CHECK  = 2'd2,
    ACT_SHIFT  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NULL_ID     = 3'd1,
    ST_NULL_PERIOD = 3'd2,
    ST_FULL        = 3'd3,
    ST_NONE_DUE    = 3'd4
  } status_e;

  localparam int unsigned MaxResults = 16;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  task_id;
    logic [31:0] now_ms;
    logic [31:0] offset_ms;
    logic [31:0] period_ms;
    logic [31:0] shift_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] due_task_id;
    logic [3:0] slot;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  // Shared datapath operations
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1
  } alu_op_e;

  typedef struct packed {
    alu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        borrow;
  } alu_rsp_t;

endpackage
`default_nettype wire

// File: src/pttt_stream_if.sv
`default_nettype none
interface pttt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/pttt_ram.sv
`default_nettype none
module pttt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: src/pttt_alu.sv
`default_nettype none
module pttt_alu (
  input  wire pttt_pkg::alu_req_t req_i,
  output pttt_pkg::alu_rsp_t      rsp_o
);
  import pttt_pkg::*;
  logic [32:0] res;

  // One adder/subtractor shared by add, shift and check
  always_comb begin
    case (req_i.op)
      OP_SUB:  res = {1'b0, req_i.a} - {1'b0, req_i.b};
      default: res = {1'b0, req_i.a} + {1'b0, req_i.b};
    endcase
    rsp_o.sum    = res[31:0];
    rsp_o.borrow = res[32];
  end
endmodule
`default_nettype wire

// File: src/periodic_task_timer_table.sv
`default_nettype none
// Periodic timer table. An item is one action (add, remove, check, shift)
// against a table of MAX_TIMERS timers held in small RAMs. A sequencer walks
// the table one entry at a time, reading the id, due and period RAMs and
// running a single 32-bit adder/subtractor for due+period, due-now and the
// min compares. Add scans up for a free slot, remove walks every entry,
// shift walks the live entries, and check walks the live entries from the
// top slot down; a rejected add or a check before the cached time ends at
// once. Each overdue beat is held back in a register so the final one can
// carry last, and the block takes no new item until the last result beat
// is taken.
module periodic_task_timer_table #(
  parameter int unsigned MAX_TIMERS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pttt_stream_if.sink   in_i,
  pttt_stream_if.source out_o
);
  import pttt_pkg::*;

  localparam int unsigned IdxW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int unsigned CntW = $clog2(MaxResults + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_READ  = 9'b000000010,
    S_WAIT  = 9'b000000100,
    S_CMP   = 9'b000001000,
    S_ADV   = 9'b000010000,
    S_MIN   = 9'b000100000,
    S_ADDW  = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_FINAL = 9'b100000000
  } state_e;

  state_e           state_q, state_d;
  in_item_t         item_q;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [MAX_TIMERS-1:0] valid_q, valid_d;
  logic [31:0]      next_chk_q, next_chk_d;
  logic [31:0]      run_min_q, run_min_d;
  logic [31:0]      t_q, t_d;
  logic [CntW-1:0]  n_q, n_d;
  out_item_t        out_q, out_d;
  logic             out_vld_q, out_vld_d;
  out_item_t        held_q, held_d;

  // RAM ports
  logic            we_id, we_due, we_per;
  logic [IdxW-1:0] waddr, raddr;
  logic [31:0]     wdue;
  logic [7:0]      rid;
  logic [31:0]     rdue, rper;

  pttt_ram #(.Width(8), .Depth(1 << IdxW)) u_id (
    .clk_i, .we_i(we_id), .waddr_i(waddr), .wdata_i(item_q.task_id),
    .raddr_i(raddr), .rdata_o(rid));
  pttt_ram #(.Width(32), .Depth(1 << IdxW)) u_due (
    .clk_i, .we_i(we_due), .waddr_i(waddr), .wdata_i(wdue),
    .raddr_i(raddr), .rdata_o(rdue));
  pttt_ram #(.Width(32), .Depth(1 << IdxW)) u_per (
    .clk_i, .we_i(we_per), .waddr_i(waddr), .wdata_i(item_q.period_ms),
    .raddr_i(raddr), .rdata_o(rper));

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  pttt_alu u_alu (.req_i(alu_req), .rsp_o(alu_rsp));

  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_TIMERS - 1);
  logic                       act_down;
  logic [IdxW-1:0]            idx_step;
  logic                       at_end;

  assign in_i.ready   = (state_q == S_IDLE) && !out_vld_q;
  assign out_o.valid  = out_vld_q;
  assign out_o.data   = out_q;
  assign raddr        = idx_q;
  assign waddr        = idx_q;
  assign act_down     = (item_q.action == ACT_CHECK);
  assign idx_step     = act_down ? idx_q - 1'b1 : idx_q + 1'b1;
  assign at_end       = act_down ? (idx_q == '0) : (idx_q == LastIdx);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    valid_d     = valid_q;
    next_chk_d  = next_chk_q;
    run_min_d   = run_min_q;
    t_d         = t_q;
    n_d         = n_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q;
    held_d      = held_q;
    we_id = 1'b0; we_due = 1'b0; we_per = 1'b0;
    wdue        = alu_rsp.sum;
    alu_req     = '{op: OP_ADD, a: t_q, b: rper};

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          n_d       = '0;
          run_min_d = '0;
          case (action_e'(in_i.data.action))
            ACT_CHECK: begin
              idx_d   = LastIdx;
              state_d = S_READ;
            end
            default: begin
              idx_d   = '0;
              state_d = S_READ;
            end
          endcase
        end
      end
      S_READ: begin
        // Check before the cached time ends at once
        if (item_q.action == ACT_CHECK && item_q.now_ms < next_chk_q) begin
          out_d   = '{due_task_id: 8'd0, slot: 4'd0, status: ST_NONE_DUE, last: 1'b1};
          out_vld_d = 1'b1;
          state_d = S_IDLE;
        end else if (item_q.action == ACT_ADD) begin
          if (item_q.task_id == 8'd0 || item_q.period_ms == 32'd0 || &valid_q) begin
            out_d.due_task_id = 8'd0;
            out_d.slot   = 4'd0;
            out_d.last   = 1'b1;
            out_d.status = (item_q.task_id == 8'd0) ? ST_NULL_ID :
                           (item_q.period_ms == 32'd0) ? ST_NULL_PERIOD : ST_FULL;
            out_vld_d = 1'b1;
            state_d = S_IDLE;
          end else if (!valid_q[idx_q]) begin
            state_d = S_ADDW;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else if (item_q.action == ACT_REMOVE) begin
          state_d = S_WAIT;
        end else begin
          state_d = valid_q[idx_q] ? S_WAIT : S_MIN;
          if (!valid_q[idx_q]) state_d = at_end ? S_FINAL : S_READ;
          if (!valid_q[idx_q] && !at_end) idx_d = idx_step;
        end
      end
      S_WAIT: begin
        // RAM data now valid
        if (item_q.action == ACT_REMOVE) begin
          if (valid_q[idx_q] && rid == item_q.task_id) valid_d[idx_q] = 1'b0;
          if (at_end) state_d = S_FINAL;
          else begin idx_d = idx_step; state_d = S_READ; end
        end else if (item_q.action == ACT_SHIFT) begin
          alu_req = '{op: OP_SUB, a: rdue, b: item_q.shift_ms};
          we_due  = 1'b1;
          wdue    = alu_rsp.borrow ? 32'd0 : alu_rsp.sum;
          if (at_end) state_d = S_FINAL;
          else begin idx_d = idx_step; state_d = S_READ; end
        end else begin
          t_d     = rdue;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        // Strictly overdue when due - now borrows
        alu_req = '{op: OP_SUB, a: t_q, b: item_q.now_ms};
        if (alu_rsp.borrow && n_q < CntW'(MaxResults)) state_d = S_ADV;
        else state_d = S_MIN;
      end
      S_ADV: begin
        alu_req = '{op: OP_ADD, a: t_q, b: rper};
        we_due  = 1'b1;
        t_d     = alu_rsp.sum;
        n_d     = n_q + 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        // After the first overdue beat, send the previously held beat once the output is free; then hold this one
        if (n_q == CntW'(1)) begin
          held_d  = '{due_task_id: rid, slot: 4'(idx_q), status: ST_OK, last: 1'b0};
          state_d = S_MIN;
        end else if (!out_vld_q || out_o.ready) begin
          out_d     = held_q;
          out_vld_d = 1'b1;
          held_d    = '{due_task_id: rid, slot: 4'(idx_q), status: ST_OK, last: 1'b0};
          state_d   = S_MIN;
        end
      end
      S_MIN: begin
        alu_req = '{op: OP_SUB, a: t_q, b: run_min_q};
        if (run_min_q == 32'd0 || alu_rsp.borrow) run_min_d = t_q;
        if (at_end) state_d = S_FINAL;
        else begin idx_d = idx_step; state_d = S_READ; end
      end
      S_ADDW: begin
        alu_req = '{op: OP_ADD, a: item_q.now_ms, b: item_q.offset_ms};
        we_id = 1'b1; we_due = 1'b1; we_per = 1'b1;
        valid_d[idx_q] = 1'b1;
        if (alu_rsp.sum < next_chk_q) next_chk_d = alu_rsp.sum;
        out_d   = '{due_task_id: 8'd0, slot: 4'(idx_q), status: ST_OK, last: 1'b1};
        out_vld_d = 1'b1;
        state_d = S_IDLE;
      end
      S_FINAL: begin
        if (!out_vld_q || out_o.ready) begin
          if (item_q.action == ACT_CHECK) begin
            next_chk_d = run_min_q;
            if (n_q == '0) begin
              out_d = '{due_task_id: 8'd0, slot: 4'd0, status: ST_NONE_DUE, last: 1'b1};
            end else begin
              out_d      = held_q;
              out_d.last = 1'b1;
            end
            out_vld_d = 1'b1;
          end else begin
            if (item_q.action == ACT_SHIFT) next_chk_d = '0;
            out_d = '{due_task_id: 8'd0, slot: 4'd0, status: ST_OK, last: 1'b1};
            out_vld_d = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      next_chk_q  <= '0;
      out_vld_q   <= 1'b0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      next_chk_q  <= next_chk_d;
      out_vld_q   <= out_vld_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) item_q <= in_i.data;
    idx_q     <= idx_d;
    run_min_q <= run_min_d;
    t_q       <= t_d;
    out_q     <= out_d;
    held_q    <= held_d;
  end

  // Hold the result payload while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |=> $stable(out_q))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> state_q == S_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(MaxResults))
    else $error("result count overflow");
endmodule
`default_nettype wire

// File: test/pttt_stream_if.sv
`timescale 1ns / 1ps
// Testbench copy of the stream interface is not needed; the RTL provides it.
// This file holds the scoreboard class used by the testbench top.
package pttt_tb_pkg;
  import pttt_pkg::*;

  localparam int unsigned NumTimers = 16;

  class timer_table_scoreboard;
    bit          valid_q[NumTimers];
    logic [7:0]  id_q[NumTimers];
    logic [31:0] due_q[NumTimers];
    logic [31:0] period_q[NumTimers];
    logic [31:0] check_time;
    out_item_t   pending[$];
    int          n_errors;

    function new();
      foreach (valid_q[i]) valid_q[i] = 1'b0;
      check_time = '0;
      n_errors = 0;
    endfunction

    function void push_beat(logic [7:0] id, int unsigned sl, status_e st, bit lst);
      out_item_t r;
      r.due_task_id = id;
      r.slot = sl[3:0];
      r.status = st;
      r.last = lst;
      pending.push_back(r);
    endfunction

    // Update the table for one accepted beat and queue the results it causes
    function void note_input(in_item_t it);
      int free_slot;
      int n_due;
      logic [31:0] due;
      logic [31:0] nxt;
      free_slot = -1;
      n_due = 0;
      nxt = '0;
      case (action_e'(it.action))
        ACT_ADD: begin
          if (it.task_id == 8'd0) begin
            push_beat(8'd0, 0, ST_NULL_ID, 1'b1);
          end else if (it.period_ms == 32'd0) begin
            push_beat(8'd0, 0, ST_NULL_PERIOD, 1'b1);
          end else begin
            for (int i = NumTimers - 1; i >= 0; i--) if (!valid_q[i]) free_slot = i;
            if (free_slot < 0) begin
              push_beat(8'd0, 0, ST_FULL, 1'b1);
            end else begin
              due = it.now_ms + it.offset_ms;
              valid_q[free_slot] = 1'b1;
              id_q[free_slot] = it.task_id;
              due_q[free_slot] = due;
              period_q[free_slot] = it.period_ms;
              if (due < check_time) check_time = due;
              push_beat(8'd0, free_slot, ST_OK, 1'b1);
            end
          end
        end
        ACT_REMOVE: begin
          foreach (valid_q[i]) if (valid_q[i] && id_q[i] == it.task_id) valid_q[i] = 1'b0;
          push_beat(8'd0, 0, ST_OK, 1'b1);
        end
        ACT_CHECK: begin
          if (it.now_ms < check_time) begin
            push_beat(8'd0, 0, ST_NONE_DUE, 1'b1);
          end else begin
            // Walk from the top slot down; a zero minimum reads as unset
            for (int i = NumTimers - 1; i >= 0; i--) begin
              if (valid_q[i]) begin
                due = due_q[i];
                if (it.now_ms > due && n_due < MaxResults) begin
                  due = due + period_q[i];
                  due_q[i] = due;
                  push_beat(id_q[i], i, ST_OK, 1'b0);
                  n_due++;
                end
                if (nxt == 0 || due < nxt) nxt = due;
              end
            end
            check_time = nxt;
            if (n_due == 0) push_beat(8'd0, 0, ST_NONE_DUE, 1'b1);
            else pending[pending.size() - 1].last = 1'b1;
          end
        end
        default: begin
          foreach (valid_q[i]) begin
            if (valid_q[i]) due_q[i] = (due_q[i] < it.shift_ms) ? 32'd0 : due_q[i] - it.shift_ms;
          end
          check_time = '0;
          push_beat(8'd0, 0, ST_OK, 1'b1);
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result beat %p", got);
        n_errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.due_task_id !== exp.due_task_id) begin
        $error("due_task_id: expected %0d, got %0d", exp.due_task_id, got.due_task_id);
        n_errors++;
      end
      if (got.slot !== exp.slot) begin
        $error("slot: expected %0d, got %0d", exp.slot, got.slot);
        n_errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        n_errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last);
        n_errors++;
      end
    endfunction
  endclass
endpackage

// File: test/periodic_task_timer_table_tb.sv
`timescale 1ns / 1ps
module periodic_task_timer_table_tb;
  import pttt_pkg::*;
  import pttt_tb_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;
  int unsigned n_cycles;
  bit stim_done;
  timer_table_scoreboard timer_sb;

  pttt_stream_if #(.T(in_item_t))  in_if ();
  pttt_stream_if #(.T(out_item_t)) out_if ();

  periodic_task_timer_table i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Abort on a hung run
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stall the receiver on its own pattern, with calm stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (n_cycles[9:8] == 2'd1) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Check each result beat
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) timer_sb.check_result(out_if.data);
  end

  // Send one beat, then hold valid for a random burst or drop for a gap
  task automatic send_beat(in_item_t it);
    int gap;
    in_if.data  <= it;
    in_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    timer_sb.note_input(it);
    if ($urandom_range(0, 2) == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 25);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic in_item_t make_beat(action_e act, logic [7:0] id, logic [31:0] now,
                                         logic [31:0] off, logic [31:0] per,
                                         logic [31:0] sh);
    in_item_t it;
    it.action = act;
    it.task_id = id;
    it.now_ms = now;
    it.offset_ms = off;
    it.period_ms = per;
    it.shift_ms = sh;
    return it;
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 50);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 50);
      2: return $urandom_range(0, 2000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    in_item_t it;
    logic [31:0] now;
    n_cycles = 0;
    timer_sb = new();
    in_if.valid = 1'b0;
    in_if.data = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: rejects, fill past full, wrap, check, remove, shift
    send_beat(make_beat(ACT_CHECK, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    send_beat(make_beat(ACT_ADD, 8'd0, 32'd5, 32'd5, 32'd5, 32'd0));
    send_beat(make_beat(ACT_ADD, 8'd7, 32'd5, 32'd5, 32'd0, 32'd0));
    for (int i = 0; i < 17; i++) begin
      send_beat(make_beat(ACT_ADD, (i == 0) ? 8'hFF : 8'(i + 1), 32'hFFFF_FFF0,
                          (i == 1) ? 32'hFFFF_FFFF : 32'(i * 3), (i == 2) ? 32'hFFFF_FFFF
                          : 32'd10, 32'd0));
    end
    send_beat(make_beat(ACT_CHECK, 8'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0));
    send_beat(make_beat(ACT_CHECK, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    send_beat(make_beat(ACT_REMOVE, 8'hFF, 32'd0, 32'd0, 32'd0, 32'd0));
    send_beat(make_beat(ACT_SHIFT, 8'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFF8));
    send_beat(make_beat(ACT_CHECK, 8'd0, 32'd4, 32'd0, 32'd0, 32'd0));
    send_beat(make_beat(ACT_SHIFT, 8'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF));
    send_beat(make_beat(ACT_CHECK, 8'd0, 32'd1, 32'd0, 32'd0, 32'd0));

    // Random: mostly a running clock with adds and checks, some noise
    now = 32'd0;
    for (int n = 0; n < 192; n++) begin
      now = now + $urandom_range(0, 40);
      case ($urandom_range(0, 9))
        0, 1, 2: it = make_beat(ACT_ADD, ($urandom_range(0, 15) == 0) ? 8'd0
                                : 8'($urandom_range(1, 12)), now, $urandom_range(0, 100),
                                ($urandom_range(0, 15) == 0) ? 32'd0
                                : 32'($urandom_range(1, 80)), $urandom);
        3, 4, 5: it = make_beat(ACT_CHECK, 8'($urandom), now, $urandom, $urandom, $urandom);
        6: it = make_beat(ACT_REMOVE, 8'($urandom_range(0, 12)), $urandom, $urandom,
                          $urandom, $urandom);
        7: it = make_beat(ACT_SHIFT, 8'($urandom), $urandom, $urandom, $urandom,
                          $urandom_range(0, 60));
        default: it = make_beat(action_e'($urandom_range(0, 3)), 8'($urandom), rand_time(),
                                rand_time(), rand_time(), rand_time());
      endcase
      if (it.action == ACT_SHIFT) now = now - it.shift_ms;
      send_beat(it);
    end
    in_if.valid <= 1'b0;

    // Drain, then give the block its tail latency
    while (timer_sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (timer_sb.n_errors == 0 && timer_sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
